### rtl/imadec_pkg.sv
`default_nettype none

package imadec_pkg;

   localparam int unsigned STEP_MAX = 88;

   localparam logic [1:0] CSR_OUTPUT_MODE        = 2'd0;
   localparam logic [1:0] CSR_VOLUME             = 2'd1;
   localparam logic [1:0] CSR_INITIAL_PREDICTOR  = 2'd2;
   localparam logic [1:0] CSR_INITIAL_STEP_INDEX = 2'd3;

   typedef logic [15:0] step_type;

   localparam step_type STEP_TABLE [0:STEP_MAX] = '{
      16'd7,     16'd8,     16'd9,     16'd10,    16'd11,    16'd12,    16'd13,    16'd14,
      16'd16,    16'd17,    16'd19,    16'd21,    16'd23,    16'd25,    16'd28,    16'd31,
      16'd34,    16'd37,    16'd41,    16'd45,    16'd50,    16'd55,    16'd60,    16'd66,
      16'd73,    16'd80,    16'd88,    16'd97,    16'd107,   16'd118,   16'd130,   16'd143,
      16'd157,   16'd173,   16'd190,   16'd209,   16'd230,   16'd253,   16'd279,   16'd307,
      16'd337,   16'd371,   16'd408,   16'd449,   16'd494,   16'd544,   16'd598,   16'd658,
      16'd724,   16'd796,   16'd876,   16'd963,   16'd1060,  16'd1166,  16'd1282,  16'd1411,
      16'd1552,  16'd1707,  16'd1878,  16'd2066,  16'd2272,  16'd2499,  16'd2749,  16'd3024,
      16'd3327,  16'd3660,  16'd4026,  16'd4428,  16'd4871,  16'd5358,  16'd5894,  16'd6484,
      16'd7132,  16'd7845,  16'd8630,  16'd9493,  16'd10442, 16'd11487, 16'd12635, 16'd13899,
      16'd15289, 16'd16818, 16'd18500, 16'd20350, 16'd22385, 16'd24623, 16'd27086, 16'd29794,
      16'd32767
   };

   function automatic step_type step_lookup(input logic [6:0] idx);
      step_type result;
      if (idx > 7'(STEP_MAX)) begin
         result = 16'd32767;
      end else begin
         result = STEP_TABLE[idx];
      end
      return result;
   endfunction

   function automatic logic signed [7:0] idx_adjust(input logic [2:0] mag);
      logic signed [7:0] result;
      case (mag)
         3'd4:    result = 8'sd2;
         3'd5:    result = 8'sd4;
         3'd6:    result = 8'sd6;
         3'd7:    result = 8'sd8;
         default: result = -8'sd1;
      endcase
      return result;
   endfunction

endpackage

`default_nettype wire

### rtl/ima_adpcm_nibble_decoder_core.sv
// IMA ADPCM 4-bit decoder, diff = ((2*m+1)*step)>>3 variant. Each transaction on req_ carries
// one byte of two codes, low nibble first; one rsp_ transaction is emitted per decoded nibble
// (only one when req_low_only is set), rsp_last marking the final one of the byte. req_restart
// reloads predictor and step index from the csr_ registers before decoding. All multiplications
// run through one shared multiplier: a nibble passes through diff product, accumulate/saturate
// and emit in 16-bit mode, with an extra volume product before emit in 8-bit mode; emit waits
// out any rsp_stall time. req_stall is high while a byte is in progress. csr_ writes are always
// taken; write them only while no byte is in progress.
`default_nettype none

module ima_adpcm_nibble_decoder_core
   import imadec_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_packed_byte,
   input  wire logic               req_low_only,
   input  wire logic               req_restart,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_sample,
   output logic                    rsp_last,
   output logic [6:0]              rsp_step_after,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIFF  = 3'd1;
   localparam logic [2:0] S_ACC   = 3'd2;
   localparam logic [2:0] S_SCALE = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic                nib_sel_ff, nib_sel_in;
   logic [7:0]          byte_ff, byte_in;
   logic                low_only_ff, low_only_in;
   logic signed [15:0]  pred_ff, pred_in;
   logic [6:0]          step_ff, step_in;
   logic signed [25:0]  prod_ff, prod_in;

   logic                mode_ff;
   logic [7:0]          volume_ff;
   logic signed [15:0]  init_pred_ff;
   logic [6:0]          init_step_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]  rsp_sample_ff, rsp_sample_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [6:0]          rsp_step_ff, rsp_step_in;

   logic [3:0]          code;
   logic signed [8:0]   mul_a;
   logic signed [16:0]  mul_b;
   logic [15:0]         diff_mag;
   logic signed [17:0]  diff_ext;
   logic signed [17:0]  pred_sum;
   logic signed [7:0]   idx_sum;
   logic                accept;
   logic                out_free;
   logic                is_last;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign code      = nib_sel_ff ? byte_ff[7:4] : byte_ff[3:0];
   assign is_last   = low_only_ff || nib_sel_ff;

   // shared multiplier
   always_comb begin
      if (state_ff == S_SCALE) begin
         mul_a = {pred_ff[15], pred_ff[15:8]};
         mul_b = {9'd0, volume_ff};
      end else begin
         mul_a = {5'd0, code[2:0], 1'b1};
         mul_b = {1'b0, step_lookup(step_ff)};
      end
   end

   assign diff_mag = prod_ff[18:3];
   assign diff_ext = code[3] ? -$signed({2'b00, diff_mag}) : $signed({2'b00, diff_mag});
   assign pred_sum = {{2{pred_ff[15]}}, pred_ff} + diff_ext;
   assign idx_sum  = $signed({1'b0, step_ff}) + idx_adjust(code[2:0]);

   always_comb begin
      state_in      = state_ff;
      nib_sel_in    = nib_sel_ff;
      byte_in       = byte_ff;
      low_only_in   = low_only_ff;
      pred_in       = pred_ff;
      step_in       = step_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_step_in   = rsp_step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               byte_in     = req_packed_byte;
               low_only_in = req_low_only;
               nib_sel_in  = 1'b0;
               if (req_restart) begin
                  pred_in = init_pred_ff;
                  step_in = (init_step_ff > 7'(STEP_MAX)) ? 7'(STEP_MAX) : init_step_ff;
               end
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            prod_in  = mul_a * mul_b;
            state_in = S_ACC;
         end
         S_SCALE: begin
            prod_in  = mul_a * mul_b;
            state_in = S_EMIT;
         end
         S_ACC: begin
            if (pred_sum > 18'sd32767) begin
               pred_in = 16'sh7FFF;
            end else if (pred_sum < -18'sd32768) begin
               pred_in = -16'sh8000;
            end else begin
               pred_in = pred_sum[15:0];
            end
            if (idx_sum < 8'sd0) begin
               step_in = 7'd0;
            end else if (idx_sum > 8'(STEP_MAX)) begin
               step_in = 7'(STEP_MAX);
            end else begin
               step_in = idx_sum[6:0];
            end
            state_in = mode_ff ? S_SCALE : S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = mode_ff ? {{8{prod_ff[15]}}, prod_ff[15:8]} : pred_ff;
               rsp_last_in   = is_last;
               rsp_step_in   = step_ff;
               nib_sel_in    = 1'b1;
               state_in      = is_last ? S_IDLE : S_DIFF;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pred_ff      <= 16'sd0;
         step_ff      <= 7'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pred_ff      <= pred_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      nib_sel_ff    <= nib_sel_in;
      byte_ff       <= byte_in;
      low_only_ff   <= low_only_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_step_ff   <= rsp_step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         volume_ff    <= 8'd255;
         init_pred_ff <= 16'sd0;
         init_step_ff <= 7'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OUTPUT_MODE:        mode_ff      <= csr_data[0];
            CSR_VOLUME:             volume_ff    <= csr_data[7:0];
            CSR_INITIAL_PREDICTOR:  init_pred_ff <= csr_data;
            CSR_INITIAL_STEP_INDEX: init_step_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = rsp_sample_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_step_after = rsp_step_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 7'(STEP_MAX))
      else $error("step index out of range");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DIFF)
      else $error("accepted transaction did not start decoding");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free && is_last) |=> state_ff == S_IDLE && rsp_valid_ff
      && rsp_last_ff)
      else $error("final nibble did not return to idle");

   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free && !is_last) |=> state_ff == S_DIFF && nib_sel_ff
      && !rsp_last_ff)
      else $error("low nibble emitted without moving to high nibble");

   a_narrow_sample: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free && mode_ff) |=>
      (rsp_sample_ff[15:7] == 9'h000 || rsp_sample_ff[15:7] == 9'h1FF))
      else $error("8-bit sample out of range");

endmodule

`default_nettype wire
